// File: hw/rtl/bpq_pkg.sv
// Package for the bounded priority queue: sizes, status codes and the cell command.
`default_nettype none

package bpq_pkg;

   localparam int DEPTH_DEF         = 16;
   localparam int PRIORITY_BITS_DEF = 8;
   localparam int VALUE_BITS_DEF    = 32;

   // The occupancy field of a result word has a fixed width.
   localparam int OCC_BITS = 5;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic ins;
      logic rem;
   } cmd_type;

endpackage

`default_nettype wire

// File: hw/rtl/bpq_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none

module bpq_cell #(
   parameter int PRIORITY_BITS = bpq_pkg::PRIORITY_BITS_DEF,
   parameter int VALUE_BITS    = bpq_pkg::VALUE_BITS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire bpq_pkg::cmd_type    cmd,
   input  wire [VALUE_BITS-1:0]     new_value,
   input  wire [PRIORITY_BITS-1:0]  new_priority,
   input  wire                      prev_goes,
   input  wire                      prev_valid,
   input  wire [VALUE_BITS-1:0]     prev_value,
   input  wire [PRIORITY_BITS-1:0]  prev_priority,
   input  wire                      next_valid,
   input  wire [VALUE_BITS-1:0]     next_value,
   input  wire [PRIORITY_BITS-1:0]  next_priority,
   output logic                     goes,
   output logic                     valid,
   output logic [VALUE_BITS-1:0]    value,
   output logic [PRIORITY_BITS-1:0] priority_out
);

   logic                     valid_ff, valid_in;
   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;

   // The new entry belongs at or above this cell when the cell is empty or the new entry is strictly more urgent,
   // so that it lands behind every held entry of equal priority.
   assign goes = cmd.ins && (!valid_ff || (new_priority > priority_ff));

   always_comb begin
      priority if (cmd.rem) begin
         valid_in    = next_valid;
         value_in    = next_value;
         priority_in = next_priority;
      end else if (cmd.ins && prev_goes) begin
         valid_in    = prev_valid;
         value_in    = prev_value;
         priority_in = prev_priority;
      end else if (goes) begin
         valid_in    = 1'b1;
         value_in    = new_value;
         priority_in = new_priority;
      end else begin
         valid_in    = valid_ff;
         value_in    = value_ff;
         priority_in = priority_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign valid        = valid_ff;
   assign value        = value_ff;
   assign priority_out = priority_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_priority_queue.sv
// Bounded priority queue built as a sorted chain of entry cells.
// Usage:
//   Input words arrive on req_*: req_tuser carries the operation (insert or remove),
//   req_tdata the data word and its priority. Each input word yields exactly one
//   result word on rsp_*: rsp_tuser gives the status, rsp_tdata the removed word,
//   its priority and the occupancy after the operation.
//   The cells stay sorted by descending priority, oldest first among equals, so
//   the head cell is always the next to leave. An insert compares its priority in
//   every cell at once and the cells below the insertion point shift down one
//   place; a remove shifts the whole chain up one place.
//   One word is accepted per cycle while the receiver takes each result; the result
//   appears in the cycle after accept.
//   Reset empties the queue and drops any pending result; entry contents are not
//   cleared and need no clearing pass.
//   When the receiver stalls, the result register holds its word and req_tready
//   falls until that word is taken; a new word may be accepted in the same cycle
//   in which the held result leaves.
`default_nettype none

module bounded_priority_queue #(
   parameter int DEPTH         = bpq_pkg::DEPTH_DEF,
   parameter int PRIORITY_BITS = bpq_pkg::PRIORITY_BITS_DEF,
   parameter int VALUE_BITS    = bpq_pkg::VALUE_BITS_DEF,
   localparam int REQ_DW = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
   localparam int RSP_DW = ((VALUE_BITS + PRIORITY_BITS + bpq_pkg::OCC_BITS + 7) / 8) * 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire [REQ_DW-1:0]  req_tdata,   // value, priority_req
   input  wire [0:0]         req_tuser,   // op
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // out_value, out_priority, occupancy
   output logic [1:0]        rsp_tuser    // status
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PAD = RSP_DW - VALUE_BITS - PRIORITY_BITS - bpq_pkg::OCC_BITS;

   logic                     req_fire;
   logic                     is_remove;
   logic                     full;
   logic                     empty;
   bpq_pkg::cmd_type         cmd;
   logic [VALUE_BITS-1:0]    new_value;
   logic [PRIORITY_BITS-1:0] new_priority;

   logic [CW-1:0]            count_ff, count_in;

   logic [DEPTH-1:0]         goes_w;
   logic [DEPTH-1:0]         valid_w;
   logic [VALUE_BITS-1:0]    value_w    [DEPTH];
   logic [PRIORITY_BITS-1:0] priority_w [DEPTH];

   logic                     rsp_valid_ff, rsp_valid_in;
   bpq_pkg::status_type      status_ff, status_in;
   logic [VALUE_BITS-1:0]    out_value_ff, out_value_in;
   logic [PRIORITY_BITS-1:0] out_priority_ff, out_priority_in;
   logic [bpq_pkg::OCC_BITS-1:0] occ_ff, occ_in;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;
   assign is_remove    = (req_tuser[0] == bpq_pkg::OP_REMOVE);
   assign new_value    = req_tdata[VALUE_BITS-1:0];
   assign new_priority = req_tdata[VALUE_BITS +: PRIORITY_BITS];
   assign full         = (count_ff == CW'(DEPTH));
   assign empty        = (count_ff == '0);

   assign cmd.ins = req_fire && !is_remove && !full;
   assign cmd.rem = req_fire && is_remove && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     p_goes, p_valid, n_valid;
      logic [VALUE_BITS-1:0]    p_value, n_value;
      logic [PRIORITY_BITS-1:0] p_priority, n_priority;

      if (i == 0) begin : g_first
         assign p_goes     = 1'b0;
         assign p_valid    = 1'b0;
         assign p_value    = '0;
         assign p_priority = '0;
      end else begin : g_mid
         assign p_goes     = goes_w[i-1];
         assign p_valid    = valid_w[i-1];
         assign p_value    = value_w[i-1];
         assign p_priority = priority_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign n_valid    = 1'b0;
         assign n_value    = '0;
         assign n_priority = '0;
      end else begin : g_body
         assign n_valid    = valid_w[i+1];
         assign n_value    = value_w[i+1];
         assign n_priority = priority_w[i+1];
      end

      bpq_cell #(
         .PRIORITY_BITS(PRIORITY_BITS),
         .VALUE_BITS   (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .new_value    (new_value),
         .new_priority (new_priority),
         .prev_goes    (p_goes),
         .prev_valid   (p_valid),
         .prev_value   (p_value),
         .prev_priority(p_priority),
         .next_valid   (n_valid),
         .next_value   (n_value),
         .next_priority(n_priority),
         .goes         (goes_w[i]),
         .valid        (valid_w[i]),
         .value        (value_w[i]),
         .priority_out (priority_w[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      status_in       = status_ff;
      out_value_in    = out_value_ff;
      out_priority_in = out_priority_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.rem) begin
         count_in = count_ff - 1'b1;
      end
      if (req_fire) begin
         out_value_in    = '0;
         out_priority_in = '0;
         priority if (cmd.rem) begin
            status_in       = bpq_pkg::ST_REMOVED;
            out_value_in    = value_w[0];
            out_priority_in = priority_w[0];
         end else if (cmd.ins) begin
            status_in = bpq_pkg::ST_INSERTED;
         end else if (is_remove) begin
            status_in = bpq_pkg::ST_EMPTY;
         end else begin
            status_in = bpq_pkg::ST_FULL;
         end
      end
      occ_in       = req_fire ? bpq_pkg::OCC_BITS'(count_in) : occ_ff;
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      out_value_ff    <= out_value_in;
      out_priority_ff <= out_priority_in;
      occ_ff          <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   if (PAD > 0) begin : g_pad
      assign rsp_tdata = {{PAD{1'b0}}, occ_ff, out_priority_ff, out_value_ff};
   end else begin : g_nopad
      assign rsp_tdata = {occ_ff, out_priority_ff, out_value_ff};
   end

endmodule

`default_nettype wire

// File: hw/rtl/bpq_checker.sv
// Port-level checks for the bounded priority queue, bound to the top level.
`default_nettype none

module bpq_checker #(
   parameter int DEPTH         = bpq_pkg::DEPTH_DEF,
   parameter int PRIORITY_BITS = bpq_pkg::PRIORITY_BITS_DEF,
   parameter int VALUE_BITS    = bpq_pkg::VALUE_BITS_DEF,
   localparam int REQ_DW = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
   localparam int RSP_DW = ((VALUE_BITS + PRIORITY_BITS + bpq_pkg::OCC_BITS + 7) / 8) * 8
) (
   input wire              clock,
   input wire              reset,
   input wire              req_tvalid,
   input wire              req_tready,
   input wire [REQ_DW-1:0] req_tdata,
   input wire [0:0]        req_tuser,
   input wire              rsp_tvalid,
   input wire              rsp_tready,
   input wire [RSP_DW-1:0] rsp_tdata,
   input wire [1:0]        rsp_tuser
);

   localparam int OCC_LO = VALUE_BITS + PRIORITY_BITS;

   // A held result word keeps its valid while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // Every accepted input word produces a result word in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted word produced no result");

   // Only a removal carries a data word and a priority.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != bpq_pkg::ST_REMOVED) |->
         (rsp_tdata[OCC_LO-1:0] == '0))
      else $error("nonzero payload on a result that is not a removal");

   // Refused inserts report full, refused removes empty at zero occupancy.
   a_refusal_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bpq_pkg::ST_EMPTY) |->
         (rsp_tdata[OCC_LO +: bpq_pkg::OCC_BITS] == '0))
      else $error("empty refusal with nonzero occupancy");

   logic unused_ok;
   assign unused_ok = ^req_tdata ^ req_tuser[0];

endmodule

bind bounded_priority_queue bpq_checker #(
   .DEPTH        (DEPTH),
   .PRIORITY_BITS(PRIORITY_BITS),
   .VALUE_BITS   (VALUE_BITS)
) u_bpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
